// ===== design/cffd_pkg.sv =====
// Package for the CFF DICT token decoder: token kinds, byte codes and payload types.
// No dependencies; the top module imports it.
`default_nettype none

package cffd_pkg;

  // Token kinds on the result channel.
  localparam logic [1:0] KIND_OPERAND  = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Lead bytes with a special meaning.
  localparam logic [7:0] BYTE_ESCAPE   = 8'd12;
  localparam logic [7:0] BYTE_INT16    = 8'd28;
  localparam logic [7:0] BYTE_INT32    = 8'd29;
  localparam logic [7:0] BYTE_REAL     = 8'd30;
  localparam logic [7:0] BYTE_SHORT_LO = 8'd32;
  localparam logic [7:0] BYTE_SHORT_HI = 8'd246;
  localparam logic [7:0] BYTE_POS2_LO  = 8'd247;
  localparam logic [7:0] BYTE_POS2_HI  = 8'd250;
  localparam logic [7:0] BYTE_NEG2_LO  = 8'd251;
  localparam logic [7:0] BYTE_NEG2_HI  = 8'd254;
  localparam logic [7:0] BYTE_RESERVED = 8'd255;

  // Offsets of the integer encodings.
  localparam logic [7:0]  SHORT_BIAS = 8'd139;
  localparam logic [10:0] TWO_BIAS   = 11'd108;

  // Number of trailing operand bytes for each multi-byte lead.
  localparam logic [2:0] LEN_INT16 = 3'd2;
  localparam logic [2:0] LEN_INT32 = 3'd4;
  localparam logic [2:0] LEN_TWO   = 3'd1;

  // One result token.
  typedef struct packed {
    logic [1:0]         token_kind;
    logic signed [31:0] operand_value;
    logic [8:0]         operator_code;
    logic               dict_done;
  } token_t;

endpackage

`default_nettype wire

// ===== design/cffd_if.sv =====
// Handshake channel interfaces for the CFF DICT token decoder.
// No dependencies: one interface for the byte stream and one for tokens.
`default_nettype none

interface cffd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cffd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         token_kind;
  logic signed [31:0] operand_value;
  logic [8:0]         operator_code;
  logic               dict_done;

  modport source (output valid, output token_kind, output operand_value,
                  output operator_code, output dict_done, input ready);
  modport sink (input valid, input token_kind, input operand_value,
                input operator_code, input dict_done, output ready);
endinterface

`default_nettype wire

// ===== design/cff_dict_token_decoder_top.sv =====
// CFF DICT token decoder: one DICT byte per transfer in, at most one token out.
// A token is registered to the output in the cycle after the byte that completes it.
// One byte per cycle if the output register is empty or taken in that same cycle.
// The per-byte state update and token build is one combinational pass into that register.
// Reset (synchronous, rst_n low) clears the decode state and empties the output register.
// Depends on cffd_pkg and the channel interfaces in cffd_if.sv.
`default_nettype none

module cff_dict_token_decoder_top
  import cffd_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  cffd_in_if.sink       in_ch,
  cffd_out_if.source    out_ch
);

  // Decode state.
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  lead_byte_r, lead_byte_nxt;
  logic [31:0] value_accum_r, value_accum_nxt;
  logic        escape_r, escape_nxt;

  // Output register.
  logic        out_valid_r;
  token_t      out_tok_r;

  // Per-byte decode results.
  logic        emit;
  token_t      tok;

  logic        in_xfer;
  logic [7:0]  b;
  logic        last;
  logic [2:0]  left_dec;
  logic [31:0] accum_shift;
  logic [1:0]  two_hi;
  logic [10:0] two_mag;
  logic [7:0]  short_val;

  // The output register takes a new token whenever it is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.end_of_data;

  // Datapath pieces used by the decode branches.
  assign left_dec    = bytes_left_r - 3'd1;
  assign accum_shift = {value_accum_r[23:0], b};
  assign two_hi      = (lead_byte_r <= BYTE_POS2_HI) ? 2'(lead_byte_r - BYTE_POS2_LO)
                                                     : 2'(lead_byte_r - BYTE_NEG2_LO);
  assign two_mag     = {1'b0, two_hi, b} + TWO_BIAS;
  assign short_val   = b - SHORT_BIAS;

  // Decode one byte: next state and the token it produces, if any.
  always_comb begin
    bytes_left_nxt  = bytes_left_r;
    lead_byte_nxt   = lead_byte_r;
    value_accum_nxt = value_accum_r;
    escape_nxt      = escape_r;
    emit            = 1'b0;
    tok             = '0;
    tok.dict_done   = last;

    if (escape_r) begin
      // Second byte of an escaped operator.
      escape_nxt         = 1'b0;
      bytes_left_nxt     = '0;
      lead_byte_nxt      = '0;
      value_accum_nxt    = '0;
      emit               = 1'b1;
      tok.token_kind     = KIND_OPERATOR;
      tok.operator_code  = {1'b1, b};
    end else if (bytes_left_r != 3'd0) begin
      // Trailing byte of a multi-byte operand.
      bytes_left_nxt = left_dec;
      if (lead_byte_r >= BYTE_POS2_LO && lead_byte_r <= BYTE_NEG2_HI) begin
        bytes_left_nxt  = '0;
        lead_byte_nxt   = '0;
        value_accum_nxt = '0;
        emit            = 1'b1;
        tok.token_kind  = KIND_OPERAND;
        if (lead_byte_r <= BYTE_POS2_HI) begin
          tok.operand_value = 32'(signed'({1'b0, two_mag}));
        end else begin
          tok.operand_value = -32'(signed'({1'b0, two_mag}));
        end
      end else begin
        value_accum_nxt = accum_shift;
        if (left_dec == 3'd0) begin
          lead_byte_nxt   = '0;
          value_accum_nxt = '0;
          emit            = 1'b1;
          tok.token_kind  = KIND_OPERAND;
          if (lead_byte_r == BYTE_INT16) begin
            tok.operand_value = 32'(signed'(accum_shift[15:0]));
          end else begin
            tok.operand_value = signed'(accum_shift);
          end
        end else if (last) begin
          // Data ended inside the operand.
          bytes_left_nxt  = '0;
          lead_byte_nxt   = '0;
          value_accum_nxt = '0;
          emit            = 1'b1;
          tok.token_kind  = KIND_ERROR;
        end
      end
    end else if (b >= BYTE_SHORT_LO && b <= BYTE_SHORT_HI) begin
      // One-byte operand.
      emit              = 1'b1;
      tok.token_kind    = KIND_OPERAND;
      tok.operand_value = 32'(signed'(short_val));
    end else if (b == BYTE_REAL || b == BYTE_RESERVED) begin
      // Real numbers and the reserved byte are not decoded.
      emit           = 1'b1;
      tok.token_kind = KIND_ERROR;
    end else if (b >= BYTE_POS2_LO || b == BYTE_INT16 || b == BYTE_INT32 ||
                 b == BYTE_ESCAPE) begin
      // Start of a multi-byte token.
      if (last) begin
        emit           = 1'b1;
        tok.token_kind = KIND_ERROR;
      end else if (b == BYTE_ESCAPE) begin
        escape_nxt = 1'b1;
      end else begin
        lead_byte_nxt   = b;
        value_accum_nxt = '0;
        if (b == BYTE_INT16) begin
          bytes_left_nxt = LEN_INT16;
        end else if (b == BYTE_INT32) begin
          bytes_left_nxt = LEN_INT32;
        end else begin
          bytes_left_nxt = LEN_TWO;
        end
      end
    end else begin
      // Remaining low bytes are single-byte operators.
      emit              = 1'b1;
      tok.token_kind    = KIND_OPERATOR;
      tok.operator_code = {1'b0, b};
    end
  end

  // Decode state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r  <= '0;
      lead_byte_r   <= '0;
      value_accum_r <= '0;
      escape_r      <= 1'b0;
    end else if (in_xfer) begin
      bytes_left_r  <= bytes_left_nxt;
      lead_byte_r   <= lead_byte_nxt;
      value_accum_r <= value_accum_nxt;
      escape_r      <= escape_nxt;
    end
  end

  // Output register: loaded by a byte that yields a token, emptied on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_tok_r <= tok;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.token_kind    = out_tok_r.token_kind;
  assign out_ch.operand_value = out_tok_r.operand_value;
  assign out_ch.operator_code = out_tok_r.operator_code;
  assign out_ch.dict_done     = out_tok_r.dict_done;

endmodule

`default_nettype wire
